/* src/ansi_escape_stripper_unit_defines.svh */
// assertion macros for the escape stripper
// no dependencies; included by the top level
`ifndef ANSI_ESCAPE_STRIPPER_UNIT_DEFINES_SVH
`define ANSI_ESCAPE_STRIPPER_UNIT_DEFINES_SVH

// same-cycle implication
`define AES_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication
`define AES_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

/* src/aes_pkg.sv */
// shared types and character constants for the escape stripper
// no dependencies
package aes_pkg;

   localparam int CHAR_W = 16;

   localparam logic [CHAR_W-1:0] CH_BEL   = 16'h0007;
   localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
   localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
   localparam logic [CHAR_W-1:0] CH_ESC   = 16'h001B;
   localparam logic [CHAR_W-1:0] CH_QUEST = 16'h003F;
   localparam logic [CHAR_W-1:0] CH_LBRK  = 16'h005B;
   localparam logic [CHAR_W-1:0] CH_RBRK  = 16'h005D;
   localparam logic [CHAR_W-1:0] CH_C1PAD = 16'h0080;
   localparam logic [CHAR_W-1:0] CH_BAD   = 16'h6F5F;

   typedef struct packed {
      logic              emit;
      logic [CHAR_W-1:0] out_char;
   } decision_type;

endpackage

/* src/aes_channels.sv */
// valid/ready channel interfaces for request, response and csr write
// depends on aes_pkg
interface aes_req_if import aes_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface aes_rsp_if import aes_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   modport source (output valid, output out_char, input ready);
   modport sink (input valid, input out_char, output ready);
endinterface

interface aes_csr_if ();
   logic valid;
   logic ready;
   logic wide_mode;
   modport source (output valid, output wide_mode, input ready);
   modport sink (input valid, input wide_mode, output ready);
endinterface

/* src/aes_parser.sv */
// parse state machine and per-character keep/drop decision
// depends on aes_pkg
module aes_parser import aes_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              wide_mode,
   input  logic              advance,
   input  logic [CHAR_W-1:0] char_in,
   output decision_type      decision
);

   typedef enum logic [1:0] {
      ST_NORMAL,
      ST_ESCAPE,
      ST_CSI,
      ST_OSC
   } parse_state_type;

   parse_state_type   state_ff;
   parse_state_type   state_in;
   logic [CHAR_W-1:0] c;
   logic              is_ctrl;
   logic              is_crlftab;
   logic              is_letter;
   logic              filtered;
   logic              emit;

   always_comb begin
      c          = wide_mode ? char_in : {{(CHAR_W-8){1'b0}}, char_in[7:0]};
      is_ctrl    = (c < 16'h0020);
      is_crlftab = (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
      is_letter  = ((c >= 16'h0041) && (c <= 16'h005A)) ||
                   ((c >= 16'h0061) && (c <= 16'h007A));
      // wide mode drops these before the parser sees them
      filtered   = wide_mode &&
                   ((is_ctrl && !is_crlftab && (c != CH_ESC) && (c != CH_BEL)) ||
                    (c == CH_C1PAD) || (c == CH_BAD));
      state_in   = state_ff;
      emit       = 1'b0;
      if (!filtered) begin
         case (state_ff)
            ST_NORMAL: begin
               if (c == CH_ESC) begin
                  state_in = ST_ESCAPE;
               end else if (!wide_mode && is_ctrl && !is_crlftab) begin
                  emit = 1'b0;
               end else begin
                  emit = 1'b1;
               end
            end
            ST_ESCAPE: begin
               if (c == CH_LBRK) begin
                  state_in = ST_CSI;
               end else if (c == CH_RBRK) begin
                  state_in = ST_OSC;
               end else begin
                  state_in = ST_NORMAL;
               end
            end
            ST_CSI: begin
               if (is_letter || (wide_mode && (c == CH_QUEST))) begin
                  state_in = ST_NORMAL;
               end
            end
            ST_OSC: begin
               if ((c == CH_BEL) || (c == CH_CR) || (c == CH_LF)) begin
                  state_in = ST_NORMAL;
               end
            end
            default: begin
               state_in = ST_NORMAL;
            end
         endcase
      end
      decision.emit     = emit;
      decision.out_char = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NORMAL;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/ansi_escape_stripper_unit.sv */
// top level of the escape stripper: input register, parser, response register
// depends on aes_pkg, aes_channels, aes_parser and the assertion macro header
`include "ansi_escape_stripper_unit_defines.svh"

// ansi escape stripper
// req_chan carries one terminal character per request; rsp_chan returns the
// characters that lie outside any escape sequence, in order, at most one per
// request. csr_chan writes wide_mode (0 byte strings, 1 wide characters with
// extra filtering); it is always ready, and the user must write it only while
// idle; the block does not enforce this. a request is taken into an input
// register, judged by the parser logic and, if kept, moved into the response
// register. unless rsp_chan stalls, one request per cycle is sustained; the
// single parse-state register is the only loop, updated as each character
// leaves the input stage. dropped characters leave the input stage without
// waiting for rsp_chan. when the receiver stalls the response register holds,
// the input register fills behind it, and then req_chan.ready falls until
// rsp_chan.ready returns. reset (synchronous) empties both stages, sets the
// parser to normal and clears wide_mode to byte mode.
module ansi_escape_stripper_unit import aes_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   aes_req_if.sink   req_chan,
   aes_rsp_if.source rsp_chan,
   aes_csr_if.sink   csr_chan
);

   // configuration
   logic              wide_ff;

   // input stage
   logic              s1_valid_ff;
   logic [CHAR_W-1:0] s1_char_ff;

   // response stage
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;

   decision_type      decision;
   logic              out_free;
   logic              s1_adv;
   logic              req_take;

   // response register can take a new character this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // dropped characters retire even while the response side is stalled
   assign s1_adv   = s1_valid_ff && (out_free || !decision.emit);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready  = !s1_valid_ff || s1_adv;
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.out_char = rsp_char_ff;

   aes_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .wide_mode (wide_ff),
      .advance   (s1_adv),
      .char_in   (s1_char_ff),
      .decision  (decision)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         wide_ff <= csr_chan.wide_mode;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_take) begin
         s1_char_ff <= req_chan.in_char;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_adv && decision.emit;
      end
      if (out_free && s1_adv && decision.emit) begin
         rsp_char_ff <= decision.out_char;
      end
   end

   // a held character stays in the input stage until it retires
   `AES_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff,
      "input stage lost a character")
   // a kept character always reaches the response register
   `AES_ASSERT_NXT(a_emit_lands, clock, reset, s1_adv && decision.emit,
      rsp_valid_ff && (rsp_char_ff == $past(decision.out_char)),
      "kept character did not reach the response register")
   // byte mode never returns bits above the low byte
   `AES_ASSERT_IMP(a_byte_width, clock, reset, decision.emit && !wide_ff,
      decision.out_char[CHAR_W-1:8] == '0, "byte mode character wider than 8 bits")

endmodule
